// ===== hw/rtl/bcg_pkg.sv =====
// Shared types and constants for the battery charge gauge.
// Holds register indexes, reset values, field widths and the sequencer states.
// No dependencies.
package bcg_pkg;

  localparam int SamplesDef = 8;
  localparam int AdcBitsDef = 12;

  localparam int MV_W   = 15;
  localparam int PCT_W  = 7;
  localparam int CFG12_W = 12;
  localparam int SCALE_W = 2 * CFG12_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [MV_W-1:0]  MV_MAX   = 15'd32767;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_MV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PERCENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULLSCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_Q8  = 3'd5;

  localparam logic [MV_W-1:0]    RST_FULL_MV     = 15'd4150;
  localparam logic [MV_W-1:0]    RST_EMPTY_MV    = 15'd3400;
  localparam logic [MV_W-1:0]    RST_SLEEP_MV    = 15'd3360;
  localparam logic [PCT_W-1:0]   RST_LOW_PERCENT = 7'd5;
  localparam logic [CFG12_W-1:0] RST_FULLSCALE   = 12'd3100;
  localparam logic [CFG12_W-1:0] RST_DIVIDER_Q8  = 12'd512;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_AVG   = 7'b0000010,
    ST_SCALE = 7'b0000100,
    ST_MV    = 7'b0001000,
    ST_RANGE = 7'b0010000,
    ST_PCT   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/bcg_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are zero. Uses bcg_pkg.
module bcg_mul
  import bcg_pkg::*;
#(
  parameter int A_W = SCALE_W,
  parameter int B_W = CFG12_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  output logic             busy_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int P_W = A_W + B_W;

  logic [P_W-1:0] acc_q, acc_d;
  logic [P_W-1:0] a_sh_q, a_sh_d;
  logic [B_W-1:0] b_sh_q, b_sh_d;

  always_comb begin
    acc_d  = acc_q;
    a_sh_d = a_sh_q;
    b_sh_d = b_sh_q;
    if (start_i) begin
      acc_d  = '0;
      a_sh_d = P_W'(a_i);
      b_sh_d = b_i;
    end else if (|b_sh_q) begin
      if (b_sh_q[0]) begin
        acc_d = acc_q + a_sh_q;
      end
      a_sh_d = {a_sh_q[P_W-2:0], 1'b0};
      b_sh_d = {1'b0, b_sh_q[B_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_sh_q <= '0;
    end else begin
      b_sh_q <= b_sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    a_sh_q <= a_sh_d;
  end

  assign busy_o = |b_sh_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/bcg_div.sv =====
// Restoring divider, one quotient bit per cycle over the full dividend width.
// Shared by averaging, millivolt scaling and percent. Uses bcg_pkg.
module bcg_div
  import bcg_pkg::*;
#(
  parameter int NUM_W = AdcBitsDef + SCALE_W,
  parameter int DEN_W = AdcBitsDef + 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/battery_charge_gauge.sv =====
// Battery charge gauge top level: sample accumulation, reading sequencer,
// configuration registers and output register. Uses bcg_pkg, bcg_mul, bcg_div.
//
// Each input beat is one converter sample; a sample that does not close a group
// is added to the running sum. The sample closing a group of SAMPLES_PER_READING
// starts one reading, which runs through a single bit-serial multiplier and a
// single restoring divider that yields one quotient bit per cycle; the divider
// runs up to three times per reading, for the average, the millivolts and the
// percent. No sample is taken while a reading is in progress, also while the
// finished reading waits for the previous result to leave the output register.
// One result beat leaves per reading through an output register, so a finished
// reading may wait there while the next group is collected. Configuration writes
// are always taken and belong only to times when no reading is in progress.
module battery_charge_gauge
  import bcg_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SamplesDef,
  parameter int ADC_BITS            = AdcBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ADC_BITS-1:0]   adc_sample_i,
  input  logic                  usb_present_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MV_W-1:0]       voltage_mv_o,
  output logic [PCT_W-1:0]      raw_percent_o,
  output logic [PCT_W-1:0]      shown_percent_o,
  output logic                  low_battery_o,
  output logic                  deep_sleep_o
);

  localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam int SUM_W = ADC_BITS + $clog2(SAMPLES_PER_READING + 1);
  localparam int MB_W  = (ADC_BITS > CFG12_W) ? ADC_BITS : CFG12_W;
  localparam int P_W   = SCALE_W + MB_W;
  localparam int NUM_W = ADC_BITS + SCALE_W;
  localparam int DEN_W = ADC_BITS + 8;
  localparam int PN_W  = MV_W + PCT_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_READING - 1);
  localparam logic [DEN_W-1:0] N_DEN    = DEN_W'(SAMPLES_PER_READING);
  localparam logic [DEN_W-1:0] MV_DEN   = DEN_W'(((1 << ADC_BITS) - 1) * 256);

  // configuration
  logic [MV_W-1:0]    full_q, empty_q, sleep_q;
  logic [PCT_W-1:0]   low_pct_q;
  logic [CFG12_W-1:0] fs_q, div_q8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q    <= RST_FULL_MV;
      empty_q   <= RST_EMPTY_MV;
      sleep_q   <= RST_SLEEP_MV;
      low_pct_q <= RST_LOW_PERCENT;
      fs_q      <= RST_FULLSCALE;
      div_q8_q  <= RST_DIVIDER_Q8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FULL_MV:     full_q    <= cfg_data_i[MV_W-1:0];
        REG_EMPTY_MV:    empty_q   <= cfg_data_i[MV_W-1:0];
        REG_SLEEP_MV:    sleep_q   <= cfg_data_i[MV_W-1:0];
        REG_LOW_PERCENT: low_pct_q <= cfg_data_i[PCT_W-1:0];
        REG_FULLSCALE:   fs_q      <= cfg_data_i[CFG12_W-1:0];
        REG_DIVIDER_Q8:  div_q8_q  <= cfg_data_i[CFG12_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer and datapath
  state_e           state_q, state_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             usb_q, usb_d;
  logic [MV_W-1:0]  mv_q, mv_d;
  logic [PCT_W-1:0] pct_q, pct_d;
  logic [PCT_W-1:0] shown_q, shown_d;
  logic             shown_valid_q, shown_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic [SUM_W-1:0] sum_total;
  logic             in_beat;

  logic               mul_start, mul_busy;
  logic [SCALE_W-1:0] mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [P_W-1:0]     mul_prod;
  logic               div_start, div_busy;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   div_quo;
  logic [MV_W-1:0]    mv_span;
  logic [PN_W-1:0]    pct_num;
  logic [PCT_W-1:0]   shown_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign sum_total  = sum_q + SUM_W'(adc_sample_i);
  assign mv_span    = mv_q - empty_q;
  assign pct_num    = {{PCT_W{1'b0}}, mv_span} * {{MV_W{1'b0}}, PCT_FULL};
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (!shown_valid_q) begin
      shown_next = pct_q;
    end else if (usb_q) begin
      shown_next = (pct_q > shown_q) ? pct_q : shown_q;
    end else begin
      shown_next = (pct_q < shown_q) ? pct_q : shown_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    sum_d         = sum_q;
    cnt_d         = cnt_q;
    usb_d         = usb_q;
    mv_d          = mv_q;
    pct_d         = pct_q;
    shown_d       = shown_q;
    shown_valid_d = shown_valid_q;
    mul_start     = 1'b0;
    mul_a         = SCALE_W'(div_q8_q);
    mul_b         = MB_W'(fs_q);
    div_start     = 1'b0;
    div_num       = NUM_W'(sum_total);
    div_den       = N_DEN;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (cnt_q == LAST_CNT) begin
            sum_d     = '0;
            cnt_d     = '0;
            usb_d     = usb_present_i;
            div_start = 1'b1;
            mul_start = 1'b1;
            state_d   = ST_AVG;
          end else begin
            sum_d = sum_total;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_AVG: begin
        mul_a = mul_prod[SCALE_W-1:0];
        mul_b = MB_W'(div_quo[ADC_BITS-1:0]);
        if (!div_busy && !mul_busy) begin
          mul_start = 1'b1;
          state_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        div_num = mul_prod[NUM_W-1:0];
        div_den = MV_DEN;
        if (!mul_busy) begin
          div_start = 1'b1;
          state_d   = ST_MV;
        end
      end
      ST_MV: begin
        if (!div_busy) begin
          mv_d    = (|div_quo[NUM_W-1:MV_W]) ? MV_MAX : div_quo[MV_W-1:0];
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        div_num = NUM_W'(pct_num);
        div_den = DEN_W'(full_q - empty_q);
        if (mv_q <= empty_q) begin
          pct_d   = PCT_ZERO;
          state_d = ST_OUT;
        end else if (mv_q >= full_q) begin
          pct_d   = PCT_FULL;
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_PCT;
        end
      end
      ST_PCT: begin
        if (!div_busy) begin
          pct_d   = div_quo[PCT_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          shown_d       = shown_next;
          shown_valid_d = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sum_q         <= '0;
      cnt_q         <= '0;
      shown_q       <= '0;
      shown_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sum_q         <= sum_d;
      cnt_q         <= cnt_d;
      shown_q       <= shown_d;
      shown_valid_q <= shown_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    usb_q <= usb_d;
    mv_q  <= mv_d;
    pct_q <= pct_d;
    if (out_load) begin
      voltage_mv_o    <= mv_q;
      raw_percent_o   <= pct_q;
      shown_percent_o <= shown_next;
      low_battery_o   <= !usb_q && (shown_next <= low_pct_q);
      deep_sleep_o    <= !usb_q && (mv_q <= sleep_q);
    end
  end

  assign out_valid_o = out_valid_q;

  bcg_mul #(
    .A_W(SCALE_W),
    .B_W(MB_W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .prod_o (mul_prod)
  );

  bcg_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .busy_o    (div_busy),
    .quotient_o(div_quo)
  );

endmodule

// ===== hw/rtl/bcg_checker.sv =====
// Port-level checks for the battery charge gauge, attached by bind.
// Sees only top-level ports. Uses bcg_pkg.
module bcg_checker
  import bcg_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [MV_W-1:0]  voltage_mv_o,
  input logic [PCT_W-1:0] raw_percent_o,
  input logic [PCT_W-1:0] shown_percent_o,
  input logic             low_battery_o,
  input logic             deep_sleep_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(voltage_mv_o)
      && $stable(raw_percent_o) && $stable(shown_percent_o)
      && $stable(low_battery_o) && $stable(deep_sleep_o))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> raw_percent_o <= PCT_FULL)
    else $error("raw percent above full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shown_percent_o <= PCT_FULL)
    else $error("shown percent above full");

  // a new result comes only out of a reading in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a reading");

endmodule

bind battery_charge_gauge bcg_checker u_bcg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .voltage_mv_o   (voltage_mv_o),
  .raw_percent_o  (raw_percent_o),
  .shown_percent_o(shown_percent_o),
  .low_battery_o  (low_battery_o),
  .deep_sleep_o   (deep_sleep_o)
);
